// ===== design/rls_pkg.sv =====
`timescale 1ns / 1ps

package rls_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHANCE       = 2'd0;
    localparam logic [1:0] CFG_STEP_SAMPLES = 2'd1;
    localparam logic [1:0] CFG_LOOP_CODE    = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [6:0]  CHANCE_RESET       = 7'sd0;
    localparam logic        [15:0] STEP_SAMPLES_RESET = 16'd22050;
    localparam logic        [2:0]  LOOP_CODE_RESET    = 3'd1;
    localparam logic        [6:0]  DRONE_RESET        = 7'd62;

    localparam logic signed [7:0] MUTATE_MARGIN = 8'sd10;
    localparam logic        [2:0] NOTE_CODE_MAX = 3'd4;

    // One store word holds the note code and the gate bit
    localparam int STORE_W = 4;

    typedef struct packed {
        logic [8:0] block_samples;
        logic [5:0] note_roll;
        logic [2:0] note_pick;
        logic [5:0] gate_roll;
        logic       gate_pick;
    } in_item_t;

    typedef struct packed {
        logic       step_taken;
        logic       gate_main;
        logic       gate_inverse;
        logic       pitch_update;
        logic [4:0] pitch_semitones;
        logic [6:0] drone_note;
        logic [5:0] step_position;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        acc_next;
        logic [1:0]         gates_next;
        logic [4:0]         pitch_next;
        logic [6:0]         drone_next;
        logic               wr_en;
        logic [STORE_W-1:0] wr_word;
        out_item_t          result;
    } core_upd_t;

    function automatic logic [4:0] note_semis(input logic [2:0] code);
        logic [4:0] semis;
        case (code)
            3'd0:    semis = 5'd0;
            3'd1:    semis = 5'd2;
            3'd2:    semis = 5'd3;
            3'd3:    semis = 5'd4;
            default: semis = 5'd5;
        endcase
        return semis;
    endfunction

    function automatic logic [4:0] key_semis(input logic [1:0] sect);
        logic [4:0] semis;
        case (sect)
            2'd0:    semis = 5'd0;
            2'd1:    semis = 5'd5;
            2'd2:    semis = 5'd3;
            default: semis = 5'd12;
        endcase
        return semis;
    endfunction

    function automatic logic [6:0] drone_midi(input logic [1:0] sect);
        logic [6:0] note;
        case (sect)
            2'd0:    note = 7'd62;
            2'd1:    note = 7'd69;
            2'd2:    note = 7'd65;
            default: note = 7'd62;
        endcase
        return note;
    endfunction

endpackage

// ===== design/rls_stream_if.sv =====
`timescale 1ns / 1ps

interface rls_stream_if #(
    parameter type payload_t = logic [0:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rls_ram.sv =====
`timescale 1ns / 1ps

module rls_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rls_step_core.sv =====
`timescale 1ns / 1ps

module rls_step_core #(
    parameter int STORE_DEPTH = 64,
    localparam int PosW = $clog2(STORE_DEPTH)
) (
    input  rls_pkg::in_item_t                item,
    input  logic signed [6:0]                chance,
    input  logic [15:0]                      step_samples,
    input  logic [2:0]                       loop_code,
    input  logic [15:0]                      acc,
    input  logic [PosW-1:0]                  pos,
    input  logic [1:0]                       gates,
    input  logic [4:0]                       last_pitch,
    input  logic [6:0]                       last_drone,
    input  logic [rls_pkg::STORE_W-1:0]      rd_word,
    input  logic                             rd_valid,
    output logic [PosW-1:0]                  pos_next,
    output rls_pkg::core_upd_t               upd
);

    logic [16:0]       sum;
    logic [15:0]       acc_sat;
    logic              half_hit;
    logic              step;
    logic signed [7:0] chance_s;
    logic signed [7:0] note_lim;
    logic signed [7:0] gate_lim;
    logic              mut_note;
    logic              mut_gate;
    logic [2:0]        old_note;
    logic              old_gate;
    logic [2:0]        new_note;
    logic              new_gate;
    logic [1:0]        sect;
    logic [8:0]        len_pow;
    logic              len_full;
    logic [PosW:0]     pos_inc;
    logic [PosW-1:0]   wrap_pos;
    logic [PosW-1:0]   len_mask;

    // 10 + roll for notes, -10 - roll for gates
    function automatic logic signed [7:0] MUTATE_LIM(input logic [5:0] roll,
                                                     input logic       neg);
        logic signed [7:0] lim;
        lim = rls_pkg::MUTATE_MARGIN + $signed({2'b00, roll});
        return neg ? -lim : lim;
    endfunction

    always_comb
    begin
        sum      = {1'b0, acc} + 17'(item.block_samples);
        acc_sat  = sum[16] ? 16'hFFFF : sum[15:0];
        half_hit = acc_sat >= (step_samples >> 1);
        step     = acc_sat >= step_samples;

        chance_s = {chance[6], chance};
        note_lim = MUTATE_LIM(item.note_roll, 1'b0);
        gate_lim = MUTATE_LIM(item.gate_roll, 1'b1);
        mut_note = chance_s > note_lim;
        mut_gate = chance_s < gate_lim;

        // Never-written entries read as zero
        old_note = rd_valid ? rd_word[3:1] : 3'd0;
        old_gate = rd_valid ? rd_word[0]   : 1'b0;
        new_note = mut_note
                 ? ((item.note_pick > rls_pkg::NOTE_CODE_MAX) ? rls_pkg::NOTE_CODE_MAX
                                                              : item.note_pick)
                 : old_note;
        new_gate = mut_gate ? item.gate_pick : old_gate;

        sect = 2'(6'(pos) >> 4);

        // Loop length: power of two unless capped at the store depth
        len_pow  = 9'd2 << loop_code;
        len_full = (loop_code >= 3'd6) || (len_pow >= 9'(STORE_DEPTH));
        len_mask = PosW'(len_pow - 9'd1);
        pos_inc  = {1'b0, pos} + (PosW+1)'(1);
        if (len_full)
        begin
            wrap_pos = (pos_inc == (PosW+1)'(STORE_DEPTH)) ? '0 : PosW'(pos_inc);
        end
        else
        begin
            wrap_pos = PosW'(pos_inc) & len_mask;
        end

        upd = '0;
        upd.wr_word = {new_note, new_gate};
        if (step)
        begin
            pos_next              = wrap_pos;
            upd.acc_next          = 16'd0;
            upd.gates_next        = {~new_gate, new_gate};
            upd.pitch_next        = new_gate
                                  ? (rls_pkg::note_semis(new_note) + rls_pkg::key_semis(sect))
                                  : last_pitch;
            upd.drone_next        = rls_pkg::drone_midi(sect);
            upd.wr_en             = mut_note || mut_gate;
            upd.result.step_taken = 1'b1;
            upd.result.pitch_update  = new_gate;
            upd.result.step_position = 6'(pos);
        end
        else
        begin
            pos_next       = pos;
            upd.acc_next   = acc_sat;
            upd.gates_next = half_hit ? 2'b00 : gates;
            upd.pitch_next = last_pitch;
            upd.drone_next = last_drone;
        end
        upd.result.gate_main       = upd.gates_next[0];
        upd.result.gate_inverse    = upd.gates_next[1];
        upd.result.pitch_semitones = upd.pitch_next;
        upd.result.drone_note      = upd.drone_next;
    end

endmodule

// ===== design/random_looping_step_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Random looping step sequencer.
// item_ch takes one audio block per item: its sample count plus the random
// rolls and picks used if this block lands on a step. result_ch returns one
// result per item: step flag, both gate levels, pitch update flag, held pitch,
// held drone note and the position played.
// Configuration (chance, step_samples, loop_length_code) is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while no item is
// in flight, as the block does not enforce this. An accepted item waits in the
// input register; its result is registered into the output register.
// Throughput: one item per cycle while result_ch does not stall. The note and
// gate store is a RAM read ahead at the position the sequencer will play next,
// so the read-modify-write of one step never waits on the read. When result_ch
// stalls, the finished result holds in the output register and one more item
// waits in the input register; item_ch.ready drops only when both are full.
// Reset clears the position, accumulator, gates, held pitch and per-entry
// store valid bits at once; no clearing pass is needed. The drone resets to 62.
module random_looping_step_sequencer_unit #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rls_stream_if.sink                      item_ch,
    rls_stream_if.source                    result_ch,
    input  logic                            cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PosW = $clog2(STORE_DEPTH);

    logic signed [6:0]      chance_reg;
    logic [15:0]            step_samples_reg;
    logic [2:0]             loop_code_reg;

    rls_pkg::in_item_t      in_reg;
    logic                   in_valid_reg;
    rls_pkg::out_item_t     out_reg;
    logic                   out_valid_reg;

    logic [15:0]            acc_reg;
    logic [PosW-1:0]        pos_reg;
    logic [1:0]             gates_reg;
    logic [4:0]             pitch_reg;
    logic [6:0]             drone_reg;
    logic [STORE_DEPTH-1:0] valid_reg;

    logic                   advance;
    logic [PosW-1:0]        pos_next;
    logic [PosW-1:0]        rd_addr;
    logic [rls_pkg::STORE_W-1:0] rd_word;
    rls_pkg::core_upd_t     upd;

    assign advance       = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign item_ch.ready = !in_valid_reg || advance;

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = out_reg;

    // Read ahead at the position the next item will play
    assign rd_addr = advance ? pos_next : pos_reg;

    rls_ram #(
        .WIDTH (rls_pkg::STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (advance && upd.wr_en),
        .waddr (pos_reg),
        .wdata (upd.wr_word),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    rls_step_core #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_core (
        .item         (in_reg),
        .chance       (chance_reg),
        .step_samples (step_samples_reg),
        .loop_code    (loop_code_reg),
        .acc          (acc_reg),
        .pos          (pos_reg),
        .gates        (gates_reg),
        .last_pitch   (pitch_reg),
        .last_drone   (drone_reg),
        .rd_word      (rd_word),
        .rd_valid     (valid_reg[pos_reg]),
        .pos_next     (pos_next),
        .upd          (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chance_reg       <= rls_pkg::CHANCE_RESET;
            step_samples_reg <= rls_pkg::STEP_SAMPLES_RESET;
            loop_code_reg    <= rls_pkg::LOOP_CODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rls_pkg::CFG_CHANCE:       chance_reg       <= $signed(cfg_data[6:0]);
                rls_pkg::CFG_STEP_SAMPLES: step_samples_reg <= cfg_data;
                rls_pkg::CFG_LOOP_CODE:    loop_code_reg    <= cfg_data[2:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 16'd0;
            pos_reg       <= '0;
            gates_reg     <= 2'b00;
            pitch_reg     <= 5'd0;
            drone_reg     <= rls_pkg::DRONE_RESET;
            valid_reg     <= '0;
        end
        else
        begin
            if (item_ch.ready)
            begin
                in_valid_reg <= item_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                acc_reg   <= upd.acc_next;
                pos_reg   <= pos_next;
                gates_reg <= upd.gates_next;
                pitch_reg <= upd.pitch_next;
                drone_reg <= upd.drone_next;
                if (upd.wr_en)
                begin
                    valid_reg[pos_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ch.valid && item_ch.ready)
        begin
            in_reg <= item_ch.payload;
        end
        if (advance)
        begin
            out_reg <= upd.result;
        end
    end

    a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < STORE_DEPTH)
        else $error("play position beyond store depth");

    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd.result.step_taken |=> pos_reg != $past(pos_reg))
        else $error("step did not advance the position");

    a_gates_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.step_taken |-> out_reg.gate_main != out_reg.gate_inverse)
        else $error("gate levels not complementary after a step");

    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg) && $stable(pos_reg))
        else $error("store or position changed without an item");

endmodule

// ===== tb/sv/rls_step_checker.sv =====
`timescale 1ns / 1ps

module rls_step_checker
    import rls_pkg::*;
#(
    parameter int STORE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  in_item_t              item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam int MARGIN = 10;
    // Lookup tables packed low entry first
    localparam logic [24:0] NOTE_SEMITONES = {5'd5, 5'd4, 5'd3, 5'd2, 5'd0};
    localparam logic [19:0] KEY_OFFSETS    = {5'd12, 5'd3, 5'd5, 5'd0};
    localparam logic [27:0] DRONE_NOTES    = {7'd62, 7'd65, 7'd69, 7'd62};

    logic signed [6:0] chance;
    logic [15:0]       step_samples;
    logic [2:0]        loop_code;

    logic [2:0]        note_mem [STORE_DEPTH];
    logic              gate_mem [STORE_DEPTH];
    logic [5:0]        position;
    logic [15:0]       accum;
    logic              gate_main;
    logic              gate_inv;
    logic [4:0]        held_pitch;
    logic [6:0]        held_drone;

    out_item_t         awaited_outputs [$];

    function automatic int loop_span(input logic [2:0] code);
        int span;
        span = (code >= 3'd6) ? 128 : (2 << code);
        return (span > STORE_DEPTH) ? STORE_DEPTH : span;
    endfunction

    function automatic string describe(input out_item_t r);
        return $sformatf("step=%0b gate=%0b inv=%0b upd=%0b pitch=%0d drone=%0d pos=%0d",
                         r.step_taken, r.gate_main, r.gate_inverse, r.pitch_update,
                         r.pitch_semitones, r.drone_note, r.step_position);
    endfunction

    task automatic play_block(input in_item_t blk, output out_item_t res);
        logic [16:0] sum;
        logic [5:0]  pos;
        logic [1:0]  sect;
        logic        g;
        res = '0;
        // Saturate the sample count instead of wrapping
        sum = {1'b0, accum} + 17'(blk.block_samples);
        accum = sum[16] ? 16'hFFFF : sum[15:0];
        if (accum >= (step_samples >> 1))
        begin
            gate_main = 1'b0;
            gate_inv  = 1'b0;
        end
        if (accum >= step_samples)
        begin
            pos  = position;
            sect = pos[5:4];
            if (int'(chance) > MARGIN + int'(blk.note_roll))
                note_mem[pos] = (blk.note_pick > NOTE_CODE_MAX) ? NOTE_CODE_MAX : blk.note_pick;
            if (int'(chance) < -MARGIN - int'(blk.gate_roll))
                gate_mem[pos] = blk.gate_pick;
            g = gate_mem[pos];
            if (g)
            begin
                held_pitch = NOTE_SEMITONES[note_mem[pos] * 5 +: 5] + KEY_OFFSETS[sect * 5 +: 5];
                res.pitch_update = 1'b1;
            end
            held_drone        = DRONE_NOTES[sect * 7 +: 7];
            gate_main         = g;
            gate_inv          = ~g;
            res.step_taken    = 1'b1;
            res.step_position = pos;
            // Wrap back into the loop, even if it was shortened behind us
            position = 6'((int'(pos) + 1) % loop_span(loop_code));
            accum    = '0;
        end
        res.gate_main       = gate_main;
        res.gate_inverse    = gate_inv;
        res.pitch_semitones = held_pitch;
        res.drone_note      = held_drone;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        if (!rst_n)
        begin
            chance       = CHANCE_RESET;
            step_samples = STEP_SAMPLES_RESET;
            loop_code    = LOOP_CODE_RESET;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                note_mem[i] = '0;
                gate_mem[i] = 1'b0;
            end
            position   = '0;
            accum      = '0;
            gate_main  = 1'b0;
            gate_inv   = 1'b0;
            held_pitch = '0;
            held_drone = DRONE_RESET;
            awaited_outputs.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANCE:       chance       = cfg_data[6:0];
                    CFG_STEP_SAMPLES: step_samples = cfg_data[15:0];
                    CFG_LOOP_CODE:    loop_code    = cfg_data[2:0];
                    default: ;
                endcase
            end
            // Compare before pushing: a result here belongs to an older item
            if (result_valid && result_ready)
            begin
                if (awaited_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none awaited: %s", $time, describe(result));
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (result.step_taken !== want.step_taken ||
                        result.gate_main !== want.gate_main ||
                        result.gate_inverse !== want.gate_inverse ||
                        result.pitch_update !== want.pitch_update ||
                        result.pitch_semitones !== want.pitch_semitones ||
                        result.drone_note !== want.drone_note ||
                        result.step_position !== want.step_position)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $time, describe(want), describe(result));
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                play_block(item, want);
                awaited_outputs.push_back(want);
            end
            pending = awaited_outputs.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rls_pkg::*;

    localparam int BLOCKS_PER_PHASE = 95;
    localparam int BLOCKS_PER_SLOW_PHASE = 200;
    localparam int RANDOM_PHASES = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int src_idle_pct;
    int snk_idle_pct;
    int blocks_sent;
    int results_taken;
    int hold_left;
    int mismatches;
    int pending;

    rls_stream_if #(.payload_t(in_item_t))  item_ch ();
    rls_stream_if #(.payload_t(out_item_t)) result_ch ();

    random_looping_step_sequencer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rls_step_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .item         (item_ch.payload),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result       (result_ch.payload),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus two long hold-offs to back the block up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            results_taken   <= 0;
            hold_left       <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                results_taken <= results_taken + 1;
            if (hold_left > 0)
            begin
                hold_left       <= hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (result_ch.valid && result_ch.ready &&
                     (results_taken == 250 || results_taken == 900))
            begin
                hold_left       <= 80;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic in_item_t random_block(input bit big);
        in_item_t b;
        b.note_roll = 6'($urandom_range(0, 63));
        b.note_pick = 3'($urandom_range(0, 7));
        b.gate_roll = 6'($urandom_range(0, 63));
        b.gate_pick = 1'($urandom_range(0, 1));
        if (big)
            b.block_samples = 9'($urandom_range(256, 511));
        else if ($urandom_range(0, 9) == 0)
            b.block_samples = 9'($urandom_range(0, 511));
        else
            b.block_samples = 9'($urandom_range(1, 256));
        return b;
    endfunction

    task automatic send_block(input in_item_t blk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= blk;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        blocks_sent++;
        // Swap the idle ratios, then run flat out
        if (blocks_sent == 450)
        begin
            src_idle_pct = 59;
            snk_idle_pct = 30;
        end
        else if (blocks_sent == 900)
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_config(input logic signed [6:0] ch, input logic [15:0] st,
                                input logic [2:0] code);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHANCE;
        cfg_data  <= {{9{ch[6]}}, ch};
        @(posedge clk);
        cfg_index <= CFG_STEP_SAMPLES;
        cfg_data  <= st;
        @(posedge clk);
        cfg_index <= CFG_LOOP_CODE;
        cfg_data  <= {13'd0, code};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        in_item_t          blk;
        logic signed [6:0] ch;
        logic [15:0]       st;
        logic [2:0]        lc;
        bit                big;
        int                count;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_CHANCE;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        src_idle_pct    = 30;
        snk_idle_pct    = 59;
        blocks_sent     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty, full and nominal block sizes
        for (int i = 0; i < 3; i++)
        begin
            blk = random_block(1'b0);
            blk.block_samples = (i == 0) ? 9'd0 : (i == 1) ? 9'd511 : 9'd256;
            send_block(blk);
        end
        drain();

        // Zero period, gate mutation: step on every block
        write_config(-7'sd64, 16'd0, 3'd5);
        for (int i = 0; i < 12; i++)
        begin
            blk = random_block(1'b0);
            case (i)
                0: blk.block_samples = 9'd0;
                1: blk.block_samples = 9'd511;
                2: blk.block_samples = 9'd1;
                3: blk.block_samples = 9'd256;
                default: ;
            endcase
            // Roll 63 and 54 just miss the gate threshold, 53 just hits it
            blk.gate_roll = (i == 0) ? 6'd63 : (i == 1) ? 6'd53 : (i == 2) ? 6'd54 :
                            6'($urandom_range(0, 53));
            blk.gate_pick = (i != 3);
            send_block(blk);
        end
        drain();

        // Shrink the loop below the current position; sweep every note pick
        write_config(7'sd63, 16'd0, 3'd0);
        for (int i = 0; i < 10; i++)
        begin
            blk = random_block(1'b0);
            blk.note_pick = 3'(i);
            blk.note_roll = (i == 7) ? 6'd52 : (i == 8) ? 6'd53 : (i == 9) ? 6'd63 : 6'd0;
            send_block(blk);
        end
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin ch = -7'sd64; st = 16'd441;   lc = 3'd5; end
                1: begin ch = 7'sd63;  st = 16'd441;   lc = 3'd7; end
                2: begin ch = -7'sd30; st = 16'd0;     lc = 3'd2; end
                3: begin ch = 7'sd40;  st = 16'd1;     lc = 3'd6; end
                4: begin ch = -7'sd64; st = 16'hFFFF;  lc = 3'd3; end
                5: begin ch = 7'sd20;  st = 16'd44541; lc = 3'd4; end
                default:
                begin
                    ch = 7'($urandom_range(0, 127));
                    st = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) :
                                                        16'($urandom_range(0, 1500));
                    lc = 3'($urandom_range(0, 7));
                end
            endcase
            big   = (st > 16'd8000);
            count = big ? BLOCKS_PER_SLOW_PHASE : BLOCKS_PER_PHASE;
            write_config(ch, st, lc);
            for (int i = 0; i < count; i++)
                send_block(random_block(big));
            drain();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS random_looping_step_sequencer_unit");
        else
            $display("FAIL random_looping_step_sequencer_unit");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL random_looping_step_sequencer_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rls_pkg.sv
design/rls_stream_if.sv
design/rls_ram.sv
design/rls_step_core.sv
design/random_looping_step_sequencer_unit.sv
tb/sv/rls_step_checker.sv
tb/sv/tb.sv
